[rtl/psq_pkg.sv]
`default_nettype none

package psq_pkg;

    localparam int unsigned COUNTER_BITS = 16;
    localparam int unsigned CFG_BITS = 16;
    localparam int unsigned APB_ADDR_BITS = 3;
    localparam int unsigned APB_DATA_BITS = 32;

    localparam logic [CFG_BITS-1:0] TIMEOUT_RESET = CFG_BITS'(100);
    localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET = CFG_BITS'(500);

    // Register index, taken from the word address (paddr bit 2).
    typedef enum logic {
        REG_TIMEOUT  = 1'b0,
        REG_DEBOUNCE = 1'b1
    } t_reg_index;

    typedef enum logic [1:0] {
        PH_OFF  = 2'd0,
        PH_WAIT = 2'd1,
        PH_ON   = 2'd2,
        PH_ANOM = 2'd3
    } t_phase;

    typedef logic [COUNTER_BITS-1:0] t_count;

    typedef struct packed {
        logic [CFG_BITS-1:0] power_good_timeout;
        logic [CFG_BITS-1:0] debounce_interval;
    } t_cfg;

    typedef struct packed {
        logic   rail_enable;
        logic   limiter_enable;
        logic   pmic_enable;
        t_phase phase;
    } t_result;

    function automatic t_count sat_inc(input t_count v);
        return (v == '1) ? v : v + t_count'(1);
    endfunction

endpackage

`default_nettype wire

[rtl/psq_if.sv]
`default_nettype none

interface psq_tick_if;
    logic valid;
    logic ready;
    logic power_good;
    logic button_edge;

    modport source (output valid, output power_good, output button_edge, input ready);
    modport sink (input valid, input power_good, input button_edge, output ready);
endinterface

interface psq_status_if;
    logic       valid;
    logic       ready;
    logic       rail_enable;
    logic       limiter_enable;
    logic       pmic_enable;
    logic [1:0] phase;

    modport source (
        output valid, output rail_enable, output limiter_enable,
        output pmic_enable, output phase, input ready
    );
    modport sink (
        input valid, input rail_enable, input limiter_enable,
        input pmic_enable, input phase, output ready
    );
endinterface

`default_nettype wire

[rtl/power_rail_sequencer_unit.sv]
// Each accepted tick's status word is registered into the output or skid entry.
// Throughput: one tick word per clock; a two-entry output buffer keeps input ready
// while one status word waits, so ready drops only when both entries are full.
// Reset (i_rst_n low, synchronous): phase waiting for power good, counters and the
// held press cleared, timeout 100 and debounce 500, output buffer empty.
`default_nettype none

module power_rail_sequencer_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    psq_tick_if.sink                                 i_tick,
    psq_status_if.source                             o_status,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [psq_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  wire logic [psq_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic      [psq_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                     pready
);
    import psq_pkg::*;

    t_cfg       r_cfg;
    t_reg_index reg_index;
    logic       cfg_write;

    t_result core_result;
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    logic    in_accept, out_take;

    // Configuration port. The byte offset within a word is ignored.
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = t_reg_index'(paddr[2]);

    always_comb begin
        unique case (reg_index)
            REG_TIMEOUT:  prdata = APB_DATA_BITS'(r_cfg.power_good_timeout);
            REG_DEBOUNCE: prdata = APB_DATA_BITS'(r_cfg.debounce_interval);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_good_timeout <= TIMEOUT_RESET;
            r_cfg.debounce_interval <= DEBOUNCE_RESET;
        end else if (cfg_write) begin
            unique case (reg_index)
                REG_TIMEOUT:  r_cfg.power_good_timeout <= pwdata[CFG_BITS-1:0];
                REG_DEBOUNCE: r_cfg.debounce_interval <= pwdata[CFG_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign i_tick.ready = !r_skid_valid;
    assign in_accept = i_tick.valid && i_tick.ready;
    assign out_take = o_status.valid && o_status.ready;

    psq_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (in_accept),
        .i_power_good  (i_tick.power_good),
        .i_button_edge (i_tick.button_edge),
        .i_cfg         (r_cfg),
        .o_result      (core_result)
    );

    // Output register plus skid entry; a waiting skid word refills the output register first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_accept;
            end
        end else if (in_accept) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept) begin
                r_out <= core_result;
            end
        end else if (in_accept) begin
            if (r_out_valid) begin
                r_skid <= core_result;
            end else begin
                r_out <= core_result;
            end
        end
    end

    assign o_status.valid = r_out_valid;
    assign o_status.rail_enable = r_out.rail_enable;
    assign o_status.limiter_enable = r_out.limiter_enable;
    assign o_status.pmic_enable = r_out.pmic_enable;
    assign o_status.phase = r_out.phase;

endmodule

`default_nettype wire

[rtl/psq_core.sv]
`default_nettype none

module psq_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic             i_power_good,
    input  wire logic             i_button_edge,
    input  wire psq_pkg::t_cfg    i_cfg,
    output psq_pkg::t_result      o_result
);
    import psq_pkg::*;

    t_phase r_phase, n_phase;
    t_count r_wait_ticks, n_wait_ticks;
    t_count r_since_press, n_since_press;
    logic   r_press_pending, n_press_pending;

    t_count since_inc;
    t_count wait_inc;
    logic   press_taken;
    logic   pending;

    // Debounce: the counter advances first, then the edge is judged against it.
    // Comparisons run at 32 bits, wider than the 16-bit counters and registers.
    always_comb begin
        since_inc = sat_inc(r_since_press);
        press_taken = i_button_edge &&
                      (32'(since_inc) >= 32'(i_cfg.debounce_interval));
        n_since_press = press_taken ? '0 : since_inc;
        pending = r_press_pending | press_taken;
        wait_inc = sat_inc(r_wait_ticks);
    end

    always_comb begin
        n_phase = r_phase;
        n_wait_ticks = r_wait_ticks;
        n_press_pending = pending;
        unique case (r_phase)
            PH_WAIT: begin
                if (i_power_good) begin
                    n_phase = PH_ON;
                end else begin
                    n_wait_ticks = wait_inc;
                    if (32'(wait_inc) >= 32'(i_cfg.power_good_timeout)) begin
                        n_phase = PH_ANOM;
                    end
                end
            end
            PH_ON: begin
                if (pending) begin
                    n_press_pending = 1'b0;
                    n_phase = PH_OFF;
                end
            end
            PH_OFF: begin
                if (pending) begin
                    n_press_pending = 1'b0;
                    n_wait_ticks = '0;
                    n_phase = PH_WAIT;
                end
            end
            PH_ANOM: begin
                n_press_pending = 1'b0;
            end
            default: begin
                n_phase = PH_ANOM;
            end
        endcase
    end

    // The result shows the phase after this tick.
    always_comb begin
        o_result.phase = n_phase;
        o_result.rail_enable = (n_phase == PH_WAIT) || (n_phase == PH_ON);
        o_result.limiter_enable = (n_phase == PH_ON);
        o_result.pmic_enable = (n_phase == PH_ON);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_wait_ticks <= '0;
            r_since_press <= '0;
            r_press_pending <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_wait_ticks <= n_wait_ticks;
            r_since_press <= n_since_press;
            r_press_pending <= n_press_pending;
        end
    end

endmodule

`default_nettype wire

[tb/sv/psq_status_checker.sv]
`default_nettype none

module psq_status_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    psq_tick_if                               i_tick,
    psq_status_if                             i_status,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [psq_pkg::APB_ADDR_BITS-1:0] i_paddr,
    input  logic [psq_pkg::APB_DATA_BITS-1:0] i_pwdata,
    input  logic [psq_pkg::APB_DATA_BITS-1:0] i_prdata,
    input  logic                              i_pready,
    output int                                o_mismatches,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import psq_pkg::*;

    t_cfg    settings;
    t_phase  phase;
    t_count  wait_ticks;
    t_count  press_age;
    logic    press_held;
    t_result expected_status[$];
    int      mismatches = 0;

    assign o_mismatches = mismatches;

    function automatic t_result step_sequencer(input logic pg, input logic btn);
        t_result r;
        if (press_age != '1) begin
            press_age = press_age + 1'b1;
        end
        if (btn && press_age >= settings.debounce_interval) begin
            press_age  = '0;
            press_held = 1'b1;
        end
        case (phase)
            PH_WAIT: begin
                if (pg) begin
                    phase = PH_ON;
                end else begin
                    if (wait_ticks != '1) begin
                        wait_ticks = wait_ticks + 1'b1;
                    end
                    if (wait_ticks >= settings.power_good_timeout) begin
                        phase = PH_ANOM;
                    end
                end
            end
            PH_ON: begin
                if (press_held) begin
                    press_held = 1'b0;
                    phase      = PH_OFF;
                end
            end
            PH_OFF: begin
                if (press_held) begin
                    press_held = 1'b0;
                    wait_ticks = '0;
                    phase      = PH_WAIT;
                end
            end
            default: begin
                // The anomalous phase holds until reset and drops any held press.
                press_held = 1'b0;
            end
        endcase
        r.rail_enable    = (phase == PH_WAIT) || (phase == PH_ON);
        r.limiter_enable = (phase == PH_ON);
        r.pmic_enable    = (phase == PH_ON);
        r.phase          = phase;
        return r;
    endfunction

    task automatic log_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch in %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
        end
    endtask

    always @(posedge i_clk) begin
        t_result             want;
        logic [CFG_BITS-1:0] reg_value;
        if (!i_rst_n) begin
            settings.power_good_timeout = TIMEOUT_RESET;
            settings.debounce_interval  = DEBOUNCE_RESET;
            phase      = PH_WAIT;
            wait_ticks = '0;
            press_age  = '0;
            press_held = 1'b0;
            expected_status.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (t_reg_index'(i_paddr[2]))
                        REG_TIMEOUT:  settings.power_good_timeout = i_pwdata[CFG_BITS-1:0];
                        REG_DEBOUNCE: settings.debounce_interval  = i_pwdata[CFG_BITS-1:0];
                        default: ;
                    endcase
                end else begin
                    reg_value = (t_reg_index'(i_paddr[2]) == REG_TIMEOUT) ?
                                settings.power_good_timeout : settings.debounce_interval;
                    if (i_prdata != APB_DATA_BITS'(reg_value)) begin
                        log_mismatch("register read", int'(reg_value), int'(i_prdata));
                    end
                end
            end

            // Status words are matched before the tick of this edge is predicted, since a
            // tick's status word cannot appear at the edge that accepts the tick.
            if (i_status.valid && i_status.ready) begin
                if (expected_status.size() == 0) begin
                    log_mismatch("status word count (none waiting)", 0, 1);
                end else begin
                    want = expected_status.pop_front();
                    if (i_status.rail_enable !== want.rail_enable) begin
                        log_mismatch("rail_enable", int'(want.rail_enable),
                                     int'(i_status.rail_enable));
                    end
                    if (i_status.limiter_enable !== want.limiter_enable) begin
                        log_mismatch("limiter_enable", int'(want.limiter_enable),
                                     int'(i_status.limiter_enable));
                    end
                    if (i_status.pmic_enable !== want.pmic_enable) begin
                        log_mismatch("pmic_enable", int'(want.pmic_enable),
                                     int'(i_status.pmic_enable));
                    end
                    if (i_status.phase !== want.phase) begin
                        log_mismatch("phase", int'(want.phase), int'(i_status.phase));
                    end
                end
            end

            if (i_tick.valid && i_tick.ready) begin
                expected_status.push_back(step_sequencer(i_tick.power_good,
                                                         i_tick.button_edge));
            end
        end
        o_pending <= expected_status.size();
    end

endmodule

`default_nettype wire

[tb/sv/power_rail_sequencer_unit_tb.sv]
`default_nettype none

module power_rail_sequencer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psq_pkg::*;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     idle_on = 1'b0;
    int                       stall_left = 0;
    int                       mismatch_count;
    int                       pending_count;

    psq_tick_if   tick_bus ();
    psq_status_if status_bus ();

    power_rail_sequencer_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick_bus),
        .o_status (status_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    psq_status_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick_bus),
        .i_status     (status_bus),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_mismatches (mismatch_count),
        .o_pending    (pending_count)
    );

    always #5 i_clk = ~i_clk;

    // The status sink stalls in short bursts while idling is enabled.
    always @(posedge i_clk) begin
        if (!idle_on) begin
            stall_left      <= 0;
            status_bus.ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left      <= stall_left - 1;
            status_bus.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left      <= $urandom_range(0, 2);
            status_bus.ready <= 1'b0;
        end else begin
            status_bus.ready <= 1'b1;
        end
    end

    task automatic send_tick(input logic pg, input logic btn);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            tick_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_bus.valid       <= 1'b1;
        tick_bus.power_good  <= pg;
        tick_bus.button_edge <= btn;
        do @(posedge i_clk); while (!tick_bus.ready);
    endtask

    task automatic wait_quiet();
        tick_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input t_reg_index idx,
                              input logic [APB_DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_BITS'({idx, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // Both registers are written and read back while the sequencer is quiet; the upper
    // data bits carry noise that the block must drop.
    task automatic configure(input logic [CFG_BITS-1:0] timeout_val,
                             input logic [CFG_BITS-1:0] debounce_val);
        logic [APB_DATA_BITS-CFG_BITS-1:0] junk_a;
        logic [APB_DATA_BITS-CFG_BITS-1:0] junk_b;
        junk_a = (APB_DATA_BITS-CFG_BITS)'($urandom);
        junk_b = (APB_DATA_BITS-CFG_BITS)'($urandom);
        wait_quiet();
        apb_access(1'b1, REG_TIMEOUT, {junk_a, timeout_val});
        apb_access(1'b1, REG_DEBOUNCE, {junk_b, debounce_val});
        apb_access(1'b0, REG_TIMEOUT, '0);
        apb_access(1'b0, REG_DEBOUNCE, '0);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Runs of low power good are kept shorter than the timeout so that the sequencer
    // does not latch the anomaly; a zero timeout_val lifts that limit. The last word
    // always carries power good, so no later wait starts with low ticks already counted.
    task automatic random_ticks(input int count, input int timeout_val, input int press_odds);
        int   low_run;
        logic pg;
        logic btn;
        low_run = 0;
        for (int k = 0; k < count; k++) begin
            pg = ($urandom_range(0, 3) == 0);
            if (k == count - 1 || (timeout_val > 0 && low_run >= timeout_val - 1)) begin
                pg = 1'b1;
            end
            btn = ($urandom_range(1, press_odds) == 1);
            low_run = pg ? 0 : low_run + 1;
            send_tick(pg, btn);
        end
    endtask

    initial begin
        logic [CFG_BITS-1:0] tmo;
        i_rst_n              <= 1'b0;
        tick_bus.valid       <= 1'b0;
        tick_bus.power_good  <= 1'b0;
        tick_bus.button_edge <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: presses inside the debounce window are ignored.
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);

        // Short timeout, no debounce: toggling, held presses and the wait count clear.
        configure(16'd3, 16'd0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);

        tmo = '1;
        configure(tmo, 16'd0);
        random_ticks(200, int'(tmo), 4);

        idle_on <= 1'b1;
        tmo = CFG_BITS'($urandom_range(2, 12));
        configure(tmo, CFG_BITS'($urandom_range(1, 20)));
        random_ticks(300, int'(tmo), 3);

        tmo = CFG_BITS'($urandom_range(20, 300));
        configure(tmo, '1);
        random_ticks(100, int'(tmo), 2);

        tmo = CFG_BITS'($urandom_range(20, 300));
        configure(tmo, CFG_BITS'($urandom_range(0, 6)));
        random_ticks(300, int'(tmo), 4);

        tmo = 16'd2;
        configure(tmo, CFG_BITS'($urandom_range(2, 4)));
        random_ticks(200, int'(tmo), 3);

        // Final stretch without idling: a timeout of 1 drives the sequencer into
        // the anomalous phase, where power good and presses no longer matter.
        idle_on <= 1'b0;
        configure(16'd1, 16'd0);
        random_ticks(60, 0, 3);

        wait_quiet();
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("PASS power_rail_sequencer_unit");
        end else begin
            $display("FAIL power_rail_sequencer_unit");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL power_rail_sequencer_unit");
        $finish;
    end

endmodule

`default_nettype wire

[power_rail_sequencer_unit.f]
rtl/psq_pkg.sv
rtl/psq_if.sv
rtl/psq_core.sv
rtl/power_rail_sequencer_unit.sv
tb/sv/psq_status_checker.sv
tb/sv/power_rail_sequencer_unit_tb.sv
